// File: sv/gld_pkg.sv
// Package for the GIF LZW decoder: request codes, sizes, result struct.
// No dependencies.
package gld_pkg;
    localparam int TABLE_SIZE_DEF    = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_PUSH  = 2'd1,
        REQ_PULL  = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } req_item_t;

    typedef struct packed {
        logic       byte_taken;
        logic [7:0] pixel;
        logic       pixel_valid;
        logic       string_last;
        logic       need_byte;
        logic       stream_done;
        logic       bad_code_size;
    } res_item_t;
endpackage

// File: sv/gld_if.sv
// Valid/ready channel interfaces for the decoder.
// No dependencies.
interface gld_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    modport source (output valid, req_type, data_byte, input ready);
    modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface gld_res_if;
    logic       valid;
    logic       ready;
    logic       byte_taken;
    logic [7:0] pixel;
    logic       pixel_valid;
    logic       string_last;
    logic       need_byte;
    logic       stream_done;
    logic       bad_code_size;
    modport source (output valid, byte_taken, pixel, pixel_valid, string_last,
                    need_byte, stream_done, bad_code_size, input ready);
    modport sink   (input valid, byte_taken, pixel, pixel_valid, string_last,
                    need_byte, stream_done, bad_code_size, output ready);
endinterface

// File: sv/gld_front.sv
// Front end: accepts request items into a two-entry queue.
// Depends on gld_pkg.
module gld_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gld_pkg::req_item_t  in_item,
    output logic                q_valid,
    input  logic                q_pop,
    output gld_pkg::req_item_t  q_item
);
    gld_pkg::req_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_item;
    end
endmodule

// File: sv/gld_back.sv
// Back end: decode sequencer with code tables and string stack memories.
// Depends on gld_pkg.
module gld_back #(
    parameter int TABLE_SIZE    = gld_pkg::TABLE_SIZE_DEF,
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  gld_pkg::req_item_t q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output gld_pkg::res_item_t out_item
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int SW = AW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_POP   = 6'b000010,
        S_CODE  = 6'b000100,
        S_WALK  = 6'b001000,
        S_WAIT  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg;
    logic [7:0]  suffix_mem [TABLE_SIZE];
    logic [11:0] prefix_mem [TABLE_SIZE];
    logic [7:0]  stack_mem  [TABLE_SIZE];

    logic [SW-1:0] sc_reg;
    logic [23:0]   bb_reg;
    logic [4:0]    bc_reg;
    logic [7:0]    bl_reg;
    logic [3:0]    ms_reg, cw_reg;
    logic [12:0]   ns_reg, wl_reg;
    logic [11:0]   old_reg, code_reg, c_reg;
    logic [7:0]    fc_reg;
    logic          ac_reg, done_reg;
    logic [7:0]    rd_suf_reg, rd_stk_reg;
    logic [11:0]   rd_pre_reg;
    gld_pkg::res_item_t res_reg;
    logic          ov_reg;

    // code field helpers
    logic [3:0]  w;
    logic [11:0] cw_code;
    logic [12:0] clr, ff;
    assign w       = (cw_reg < 4'd1 || cw_reg > 4'(MAX_CODE_BITS)) ? 4'(MAX_CODE_BITS)
                                                                    : cw_reg;
    assign cw_code = 12'(bb_reg & ((24'd1 << w) - 24'd1));
    assign clr     = 13'd1 << ms_reg;
    assign ff      = clr + 13'd2;

    assign out_valid = ov_reg;
    assign out_item  = res_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && !ov_reg;

    logic [AW-1:0] walk_a;
    assign walk_a = code_reg[AW-1:0];

    // memories
    always_ff @(posedge clk)
    begin
        rd_suf_reg <= suffix_mem[walk_a];
        rd_pre_reg <= prefix_mem[walk_a];
        rd_stk_reg <= stack_mem[sc_reg[AW-1:0] - AW'(1)];
        if (state_reg == S_WALK && code_reg >= ff[11:0] && code_reg[11:0] == code_reg
            && sc_reg < SW'(TABLE_SIZE - 1) && 1'b0)
            stack_mem[0] <= 8'd0;
        if (state_reg == S_FIN && ns_reg < wl_reg && ns_reg < 13'(TABLE_SIZE))
        begin
            suffix_mem[ns_reg[AW-1:0]] <= code_reg[7:0];
            prefix_mem[ns_reg[AW-1:0]] <= old_reg;
        end
        if (stk_we) stack_mem[stk_wa] <= stk_wd;
    end

    logic          stk_we;
    logic [AW-1:0] stk_wa;
    logic [7:0]    stk_wd;
    always_comb
    begin
        stk_we = 1'b0;
        stk_wa = sc_reg[AW-1:0];
        stk_wd = rd_suf_reg;
        if (state_reg == S_CODE && !(cw_code == clr[11:0]) && !(cw_code == clr[11:0] + 12'd1)
            && !ac_reg && bc_reg >= {1'b0, w} && {1'b0, cw_code} >= ns_reg)
        begin
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = fc_reg;
        end
        else if (state_reg == S_WALK && !(code_reg >= ff[11:0] && sc_reg < SW'(TABLE_SIZE-1)))
        begin
            stk_we = (sc_reg < SW'(TABLE_SIZE));
            stk_wd = code_reg[7:0];
        end
        else if (state_reg == S_WAIT)
        begin
            stk_we = (sc_reg < SW'(TABLE_SIZE));
            stk_wd = rd_suf_reg;
        end
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sc_reg <= '0; bb_reg <= '0; bc_reg <= '0; bl_reg <= '0;
            ms_reg <= 4'd8; cw_reg <= 4'd9; ns_reg <= 13'd258; wl_reg <= 13'd512;
            old_reg <= '0; fc_reg <= '0; ac_reg <= 1'b0; done_reg <= 1'b0;
            ov_reg <= 1'b0; res_reg <= '0; code_reg <= '0; c_reg <= '0;
        end
        else
        begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        res_reg <= '0;
                        case (q_item.req_type)
                            gld_pkg::REQ_START:
                            begin
                                if (q_item.data_byte >= 8'd2 && q_item.data_byte <= 8'd9)
                                begin
                                    ms_reg <= q_item.data_byte[3:0];
                                    cw_reg <= q_item.data_byte[3:0] + 4'd1;
                                    wl_reg <= 13'd1 << (q_item.data_byte[3:0] + 4'd1);
                                    ns_reg <= (13'd1 << q_item.data_byte[3:0]) + 13'd2;
                                    old_reg <= '0; fc_reg <= '0;
                                    done_reg <= 1'b0;
                                    res_reg.stream_done <= 1'b0;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                    res_reg.bad_code_size <= 1'b1;
                                    res_reg.stream_done <= 1'b1;
                                end
                                bb_reg <= '0; bc_reg <= '0; bl_reg <= '0;
                                sc_reg <= '0; ac_reg <= 1'b0;
                                ov_reg <= 1'b1;
                            end
                            gld_pkg::REQ_PUSH:
                            begin
                                res_reg.stream_done <= done_reg;
                                if (!done_reg)
                                begin
                                    if (bl_reg == 8'd0)
                                    begin
                                        if (q_item.data_byte == 8'd0)
                                        begin
                                            done_reg <= 1'b1;
                                            res_reg.stream_done <= 1'b1;
                                        end
                                        else bl_reg <= q_item.data_byte;
                                        res_reg.byte_taken <= 1'b1;
                                    end
                                    else if (bc_reg <= 5'd16)
                                    begin
                                        bb_reg <= bb_reg | (24'(q_item.data_byte) << bc_reg);
                                        bc_reg <= bc_reg + 5'd8;
                                        bl_reg <= bl_reg - 8'd1;
                                        res_reg.byte_taken <= 1'b1;
                                    end
                                end
                                ov_reg <= 1'b1;
                            end
                            gld_pkg::REQ_PULL:
                                state_reg <= (sc_reg != '0) ? S_POP : S_CODE;
                            default:
                            begin
                                res_reg.stream_done <= done_reg;
                                ov_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_POP:
                begin
                    // stack read address settles, then pop
                    state_reg <= S_FIN;
                    c_reg <= 12'hFFF;
                end
                S_CODE:
                begin
                    if (bc_reg < {1'b0, w})
                    begin
                        res_reg.need_byte <= !done_reg;
                        res_reg.stream_done <= done_reg;
                        ov_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        bb_reg <= bb_reg >> w;
                        bc_reg <= bc_reg - {1'b0, w};
                        if (cw_code == clr[11:0])
                        begin
                            cw_reg <= ms_reg + 4'd1;
                            wl_reg <= 13'd1 << (ms_reg + 4'd1);
                            ns_reg <= ff;
                            ac_reg <= 1'b1;
                        end
                        else if (cw_code == clr[11:0] + 12'd1)
                        begin
                            done_reg <= 1'b1;
                            bb_reg <= '0; bc_reg <= '0; ac_reg <= 1'b0;
                            res_reg.stream_done <= 1'b1;
                            ov_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if (ac_reg)
                        begin
                            ac_reg <= 1'b0;
                            old_reg <= ({1'b0, cw_code} >= ns_reg) ? 12'd0 : cw_code;
                            fc_reg <= ({1'b0, cw_code} >= ns_reg) ? 8'd0 : cw_code[7:0];
                            res_reg.pixel <= ({1'b0, cw_code} >= ns_reg) ? 8'd0
                                                                         : cw_code[7:0];
                            res_reg.pixel_valid <= 1'b1;
                            res_reg.string_last <= 1'b1;
                            res_reg.stream_done <= done_reg;
                            ov_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if ({1'b0, cw_code} >= ns_reg)
                        begin
                            c_reg <= ns_reg[11:0];
                            code_reg <= old_reg;
                            sc_reg <= SW'(1);
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            c_reg <= cw_code;
                            code_reg <= cw_code;
                            sc_reg <= '0;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    // tables read at code_reg appear next cycle
                    if (code_reg >= ff[11:0] && sc_reg < SW'(TABLE_SIZE - 1))
                        state_reg <= S_WAIT;
                    else
                    begin
                        if (sc_reg < SW'(TABLE_SIZE)) sc_reg <= sc_reg + SW'(1);
                        state_reg <= S_FIN;
                    end
                end
                S_WAIT:
                begin
                    if (sc_reg < SW'(TABLE_SIZE)) sc_reg <= sc_reg + SW'(1);
                    code_reg <= rd_pre_reg;
                    state_reg <= S_WALK;
                end
                S_FIN:
                begin
                    if (c_reg != 12'hFFF || state_reg != S_FIN) ;
                    if (sc_reg != '0 && rd_ok_reg)
                    begin
                        if (c_reg_new_reg)
                        begin
                            if (ns_reg < wl_reg && ns_reg < 13'(TABLE_SIZE))
                                ns_reg <= ns_reg + 13'd1;
                            if ((ns_reg < wl_reg && ns_reg < 13'(TABLE_SIZE)
                                 ? ns_reg + 13'd1 : ns_reg) >= wl_reg
                                && cw_reg < 4'(MAX_CODE_BITS))
                            begin
                                wl_reg <= wl_reg << 1;
                                cw_reg <= cw_reg + 4'd1;
                            end
                            old_reg <= c_reg;
                            fc_reg <= code_reg[7:0];
                        end
                        sc_reg <= sc_reg - SW'(1);
                        res_reg.pixel <= rd_stk_reg;
                        res_reg.pixel_valid <= 1'b1;
                        res_reg.string_last <= (sc_reg == SW'(1));
                        res_reg.stream_done <= done_reg;
                        ov_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // FIN waits on rd_ok_reg: its first pass lets the stack read settle after the last write
    logic rd_ok_reg, c_reg_new_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
            c_reg_new_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= (state_reg == S_FIN) && !rd_ok_reg;
            if (state_reg == S_POP) c_reg_new_reg <= 1'b0;
            else if (state_reg == S_CODE) c_reg_new_reg <= 1'b1;
        end
    end
endmodule

// File: sv/gif_lzw_decoder.sv
// GIF LZW decoder top level: request queue front end and decode back end.
// A pull that decodes a new code walks the prefix chain through the WALK and WAIT
// states per character (registered table read), then pops the first pixel.
// Reset (rst_n low, async) empties the queue and restores the default image
// state; the code tables and stack are not cleared.
module gif_lzw_decoder #(
    parameter int TABLE_SIZE    = gld_pkg::TABLE_SIZE_DEF,
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    gld_req_if.sink  req,
    gld_res_if.source res
);
    gld_pkg::req_item_t in_item, q_item;
    gld_pkg::res_item_t out_item;
    logic q_valid, q_pop;

    assign in_item.req_type  = req.req_type;
    assign in_item.data_byte = req.data_byte;

    gld_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_item(in_item),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    gld_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .out_valid(res.valid), .out_ready(res.ready), .out_item(out_item)
    );

    assign res.byte_taken    = out_item.byte_taken;
    assign res.pixel         = out_item.pixel;
    assign res.pixel_valid   = out_item.pixel_valid;
    assign res.string_last   = out_item.string_last;
    assign res.need_byte     = out_item.need_byte;
    assign res.stream_done   = out_item.stream_done;
    assign res.bad_code_size = out_item.bad_code_size;
endmodule

// File: sv/gld_checker.sv
// Port-level checks for the decoder, bound to the top level.
// Depends on gif_lzw_decoder port names only.
module gld_checker (
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input logic pixel_valid,
    input logic string_last,
    input logic need_byte,
    input logic byte_taken,
    input logic bad_code_size,
    input logic stream_done
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid) else $error("result dropped");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && string_last |-> pixel_valid) else $error("last without pixel");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $countones({pixel_valid, need_byte, byte_taken, bad_code_size}) <= 1)
        else $error("mixed result");
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_code_size |-> stream_done) else $error("bad size not done");
endmodule

bind gif_lzw_decoder gld_checker u_chk (
    .clk(clk), .rst_n(rst_n), .res_valid(res.valid), .res_ready(res.ready),
    .pixel_valid(res.pixel_valid), .string_last(res.string_last),
    .need_byte(res.need_byte), .byte_taken(res.byte_taken),
    .bad_code_size(res.bad_code_size), .stream_done(res.stream_done)
);

// File: test/tb_top.sv
// Testbench for gif_lzw_decoder: random and directed LZW images with a scoreboard.
// Depends on gld_pkg, gld_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import gld_pkg::*;

    // Mirror of the decoder state; predicts one result per accepted item
    class lzw_scoreboard;
        bit [7:0]    sfx_mem [TABLE_SIZE_DEF];
        bit [11:0]   pfx_mem [TABLE_SIZE_DEF];
        bit [7:0]    chr_stack [TABLE_SIZE_DEF];
        int unsigned stack_n, bit_buf, bit_n, blk_left, min_sz, code_w;
        int unsigned free_slot, w_limit, prev_code, first_chr;
        bit          after_clr, done;
        res_item_t   pending [$];
        int          errors, checked, pixels;
        bit          last_pull_empty;

        function void start_image(int unsigned sz);
            min_sz    = sz & 4'hF;
            code_w    = min_sz + 1;
            w_limit   = 1 << code_w;
            free_slot = (1 << min_sz) + 2;
            bit_buf   = 0;
            bit_n     = 0;
            blk_left  = 0;
            stack_n   = 0;
            prev_code = 0;
            first_chr = 0;
            after_clr = 0;
            done      = 0;
        endfunction

        function void push_chr(int unsigned v);
            if (stack_n < TABLE_SIZE_DEF) begin
                chr_stack[stack_n] = v[7:0];
                stack_n++;
            end
        endfunction

        function void pop_chr(ref res_item_t r);
            stack_n--;
            r.pixel       = chr_stack[stack_n % TABLE_SIZE_DEF];
            r.pixel_valid = 1'b1;
            r.string_last = (stack_n == 0);
        endfunction

        function void decode_pull(ref res_item_t r);
            int unsigned clr, eoi, ffree, w, c, code;
            clr   = 1 << min_sz;
            eoi   = clr + 1;
            ffree = clr + 2;
            if (stack_n > 0) begin
                pop_chr(r);
                return;
            end
            forever begin
                w = code_w;
                if (w < 1 || w > MAX_CODE_BITS_DEF)
                    w = MAX_CODE_BITS_DEF;
                if (bit_n < w) begin
                    r.need_byte = !done;
                    return;
                end
                c       = bit_buf & ((1 << w) - 1);
                bit_buf = (bit_buf >> w) & 24'hFFFFFF;
                bit_n  -= w;
                if (c == clr) begin
                    code_w    = min_sz + 1;
                    w_limit   = 1 << code_w;
                    free_slot = ffree;
                    after_clr = 1;
                    continue;
                end
                if (c == eoi) begin
                    done      = 1;
                    bit_buf   = 0;
                    bit_n     = 0;
                    after_clr = 0;
                    return;
                end
                if (after_clr) begin
                    after_clr = 0;
                    if (c >= free_slot)
                        c = 0;
                    prev_code     = c;
                    first_chr     = c & 8'hFF;
                    r.pixel       = c[7:0];
                    r.pixel_valid = 1'b1;
                    r.string_last = 1'b1;
                    return;
                end
                code    = c;
                stack_n = 0;
                // KwKwK: code not yet in the table
                if (c >= free_slot) begin
                    c    = free_slot;
                    code = prev_code;
                    push_chr(first_chr);
                end
                while (code >= ffree && stack_n < TABLE_SIZE_DEF - 1) begin
                    push_chr(sfx_mem[code % TABLE_SIZE_DEF]);
                    code = pfx_mem[code % TABLE_SIZE_DEF];
                end
                push_chr(code);
                if (free_slot < w_limit && free_slot < TABLE_SIZE_DEF) begin
                    sfx_mem[free_slot] = code[7:0];
                    pfx_mem[free_slot] = prev_code[11:0];
                    free_slot++;
                end
                if (free_slot >= w_limit && code_w < MAX_CODE_BITS_DEF) begin
                    w_limit <<= 1;
                    code_w++;
                end
                prev_code = c & 12'hFFF;
                first_chr = code & 8'hFF;
                pop_chr(r);
                return;
            end
        endfunction

        // Accepted request: work out the result it must produce
        function void note_item(req_t rq, bit [7:0] b);
            res_item_t r;
            r = '0;
            case (rq)
                REQ_START: begin
                    if (b >= 2 && b <= 9)
                        start_image(b);
                    else begin
                        bit_buf   = 0;
                        bit_n     = 0;
                        blk_left  = 0;
                        stack_n   = 0;
                        after_clr = 0;
                        done      = 1;
                        r.bad_code_size = 1'b1;
                    end
                end
                REQ_PUSH: begin
                    if (!done) begin
                        if (blk_left == 0) begin
                            if (b == 0)
                                done = 1;
                            else
                                blk_left = b;
                            r.byte_taken = 1'b1;
                        end else if (bit_n <= 16) begin
                            bit_buf = (bit_buf | (b << bit_n)) & 24'hFFFFFF;
                            bit_n  += 8;
                            blk_left--;
                            r.byte_taken = 1'b1;
                        end
                    end
                end
                REQ_PULL: begin
                    decode_pull(r);
                    last_pull_empty = !r.pixel_valid;
                    if (r.pixel_valid)
                        pixels++;
                end
                default: ;
            endcase
            r.stream_done = done;
            pending.push_back(r);
        endfunction

        function void check_item(res_item_t got);
            res_item_t exp_r;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at result %0d: expected %p, got %p",
                             checked, exp_r, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gld_req_if req_ch ();
    gld_res_if res_ch ();

    gif_lzw_decoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .res   (res_ch.source)
    );

    lzw_scoreboard sb = new;
    int  src_idle_pct, sink_idle_pct, hold_cycles, n_images;
    bit  [7:0] img_bytes [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_NOP;
        req_ch.data_byte = '0;
        res_ch.ready     = 1'b0;
    end

    // Receiver: random ready, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0) begin
            res_ch.ready = 1'b0;
            hold_cycles--;
        end else
            res_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        res_item_t got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.byte_taken    = res_ch.byte_taken;
            got.pixel         = res_ch.pixel;
            got.pixel_valid   = res_ch.pixel_valid;
            got.string_last   = res_ch.string_last;
            got.need_byte     = res_ch.need_byte;
            got.stream_done   = res_ch.stream_done;
            got.bad_code_size = res_ch.bad_code_size;
            sb.check_item(got);
        end
    end

    // Offer one item; called at a falling edge, returns at one
    task send_item(req_t rq, bit [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.req_type  = rq;
        req_ch.data_byte = b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_item(rq, b);
        @(negedge clk);
    endtask

    // Build the byte stream of one image: codes packed LSB first, in sub-blocks
    task build_image(int unsigned sz, int ncodes, bit lead_clear, bit literals_only,
                     bit with_end, int max_blk);
        int unsigned clr, w, lim, slot, c, acc, nacc;
        bit ac;
        bit [7:0] data [$];
        int k, len;
        clr  = 1 << sz;
        w    = sz + 1;
        lim  = 1 << w;
        slot = clr + 2;
        ac   = 0;
        acc  = 0;
        nacc = 0;
        img_bytes.delete();
        for (k = -1; k <= ncodes; k++) begin
            if (k == -1 && !lead_clear)
                continue;
            if (k == ncodes && !with_end)
                break;
            if (k == -1)
                c = clr;
            else if (k == ncodes)
                c = clr + 1;
            else if (literals_only)
                c = $urandom_range(clr - 1);
            else begin
                case ($urandom_range(19))
                    0:       c = clr;
                    1:       c = $urandom_range(lim - 1, slot < lim ? slot : lim - 1);
                    2, 3:    c = slot;
                    default: c = $urandom_range(slot);
                endcase
                if (c == clr + 1)
                    c = 0;
            end
            acc  = acc | (c << nacc);
            nacc += w;
            while (nacc >= 8) begin
                data.push_back(acc[7:0]);
                acc >>= 8;
                nacc -= 8;
            end
            // follow the decoder's table growth to keep the widths in step
            if (c == clr) begin
                w    = sz + 1;
                lim  = 1 << w;
                slot = clr + 2;
                ac   = 1;
            end else if (ac)
                ac = 0;
            else if (c != clr + 1) begin
                if (slot < lim && slot < TABLE_SIZE_DEF)
                    slot++;
                if (slot >= lim && w < MAX_CODE_BITS_DEF) begin
                    lim <<= 1;
                    w++;
                end
            end
        end
        if (nacc > 0)
            data.push_back(acc[7:0]);
        while (data.size() > 0) begin
            len = $urandom_range(max_blk, 1);
            if (len > data.size())
                len = data.size();
            img_bytes.push_back(len);
            repeat (len)
                img_bytes.push_back(data.pop_front());
        end
        img_bytes.push_back(8'd0);
    endtask

    // Feed one image and pull pixels until the decoder runs dry
    task run_image(int unsigned sz, bit noisy);
        int idx, guard;
        bit do_pull;
        n_images++;
        send_item(REQ_START, sz);
        idx   = 0;
        guard = 0;
        sb.last_pull_empty = 0;
        while (!(idx >= img_bytes.size() && sb.last_pull_empty) && guard < 40000) begin
            guard++;
            do_pull = (idx >= img_bytes.size())
                   || (sb.bit_n > 16 && sb.blk_left != 0)
                   || ($urandom_range(99) < 55);
            if (noisy && $urandom_range(29) == 0)
                send_item(req_t'($urandom_range(3)), $urandom_range(255));
            else if (do_pull)
                send_item(REQ_PULL, $urandom_range(255));
            else begin
                send_item(REQ_PUSH, img_bytes[idx]);
                idx++;
            end
        end
    endtask

    task random_images(int n);
        int unsigned sz;
        repeat (n) begin
            sz = ($urandom_range(3) == 0) ? 9 : $urandom_range(9, 2);
            build_image(sz, $urandom_range(14, 3), $urandom_range(5) != 0, 1'b0,
                        $urandom_range(3) != 0, ($urandom_range(7) == 0) ? 255 : 6);
            run_image(sz, $urandom_range(3) == 0);
        end
    endtask

    initial
    begin
        int k;
        src_idle_pct  = 34;
        sink_idle_pct = 76;
        hold_cycles   = 0;
        n_images      = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: requests straight after reset, bad sizes, refused bytes, no-ops
        send_item(REQ_PULL, 8'hFF);
        send_item(REQ_PUSH, 8'd3);
        send_item(REQ_NOP, 8'hA5);
        send_item(REQ_START, 8'd0);
        send_item(REQ_PUSH, 8'd5);
        send_item(REQ_PULL, 8'h00);
        send_item(REQ_START, 8'd1);
        send_item(REQ_START, 8'd10);
        send_item(REQ_START, 8'hFF);
        send_item(REQ_NOP, 8'h5A);
        send_item(REQ_START, 8'd2);
        send_item(REQ_PULL, 8'h00);
        send_item(REQ_PUSH, 8'd0);
        send_item(REQ_PUSH, 8'd7);
        send_item(REQ_PULL, 8'hFF);
        // Directed images: smallest and largest size, no leading clear, no end code
        build_image(2, 6, 1'b1, 1'b0, 1'b1, 3);
        run_image(2, 1'b0);
        build_image(9, 6, 1'b0, 1'b0, 1'b1, 255);
        run_image(9, 1'b0);
        build_image(4, 5, 1'b1, 1'b0, 1'b0, 2);
        run_image(4, 1'b0);

        random_images(8);
        src_idle_pct  = 76;
        sink_idle_pct = 34;
        random_images(8);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // long receiver hold-off while the sender keeps offering
        hold_cycles = 400;
        random_images(8);
        // one long image of literals fills the code table up to 12 bits
        build_image(2, 4200, 1'b1, 1'b1, 1'b1, 255);
        run_image(2, 1'b0);
        for (k = 0; k < 4; k++)
            random_images(1);
        req_ch.valid = 1'b0;

        // Drain
        k = 0;
        while (sb.pending.size() != 0 && k < 200000) begin
            @(posedge clk);
            k++;
        end
        repeat (100) @(posedge clk);
        $display("Decoded %0d images (sizes 2 to 9, bad starts, full table), %0d pixels,",
                 n_images, sb.pixels);
        $display("%0d results checked, %0d mismatches, %0d left waiting",
                 sb.checked, sb.errors, sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: gif_lzw_decoder.f
sv/gld_pkg.sv
sv/gld_if.sv
sv/gld_front.sv
sv/gld_back.sv
sv/gif_lzw_decoder.sv
sv/gld_checker.sv
test/tb_top.sv
